[hdl/argb_pixel_blend_core_macros.svh]
// assertion macros used by the pixel blend top level
`ifndef ARGB_PIXEL_BLEND_CORE_MACROS_SVH
`define ARGB_PIXEL_BLEND_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define APB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("apb assertion failed");

// property checked on every clock edge, reset included
`define APB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("apb assertion failed");

`else

`define APB_ASSERT(lbl, clk, rstn, prop)
`define APB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hdl/apb_pkg.sv]
// types and constants for the argb pixel blend core
package apb_pkg;

    localparam int PIX_W = 32;
    localparam int CH_W  = 8;

    typedef enum logic [1:0] {
        MODE_SOLID = 2'd0,
        MODE_BLEND = 2'd1,
        MODE_HALF  = 2'd2,
        MODE_KEY   = 2'd3
    } blend_mode_t;

    typedef struct packed {
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dest;
    } pix_pair_t;

    localparam logic [PIX_W-1:0] MASK_ALPHA = 32'hFF00_0000;
    localparam logic [PIX_W-1:0] MASK_HALF  = 32'h00FE_FEFE;
    localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [CH_W-1:0]  ALPHA_CLEAR  = 8'h00;

endpackage

[hdl/apb_in_stage.sv]
// input register holding one dest/src pixel pair
module apb_in_stage
    import apb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // dest_pixel [31:0], src_pixel [63:32]
    input  logic             advance,
    output logic             pair_valid,
    output pix_pair_t        pair
);

    logic      valid_reg;
    logic      valid_next;
    pix_pair_t pair_reg;

    // slot frees up when the held pair moves on to the result register
    assign s_axis_tready = !valid_reg || advance;

    always_comb
    begin
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            pair_reg.dest <= s_axis_tdata[31:0];
            pair_reg.src  <= s_axis_tdata[63:32];
        end
    end

    assign pair_valid = valid_reg;
    assign pair       = pair_reg;

endmodule

[hdl/apb_blend_alu.sv]
// combinational pixel operation for the four blend modes
module apb_blend_alu
    import apb_pkg::*;
(
    input  blend_mode_t      mode,
    input  pix_pair_t        pair,
    output logic [PIX_W-1:0] result
);

    logic [CH_W-1:0]   alpha;
    logic [CH_W-1:0]   inv_alpha;
    logic [2*CH_W-1:0] mix_r;
    logic [2*CH_W-1:0] mix_g;
    logic [2*CH_W-1:0] mix_b;
    logic [PIX_W-1:0]  mixed;
    logic [PIX_W-1:0]  halved;
    logic              opaque;

    assign alpha     = pair.src[31:24];
    assign inv_alpha = ALPHA_OPAQUE - alpha;
    assign opaque    = (alpha == ALPHA_OPAQUE);

    // s*a + d*(255-a) never exceeds 16 bits, so channels stay apart
    assign mix_r = pair.src[23:16] * alpha + pair.dest[23:16] * inv_alpha;
    assign mix_g = pair.src[15:8]  * alpha + pair.dest[15:8]  * inv_alpha;
    assign mix_b = pair.src[7:0]   * alpha + pair.dest[7:0]   * inv_alpha;
    assign mixed = {ALPHA_OPAQUE, mix_r[15:8], mix_g[15:8], mix_b[15:8]};

    // low bits dropped before the add, no carry between channels
    assign halved = (((pair.dest & MASK_HALF) >> 1) + ((pair.src & MASK_HALF) >> 1))
                    | MASK_ALPHA;

    always_comb
    begin
        unique case (mode)
            MODE_SOLID:
            begin
                result = pair.src | MASK_ALPHA;
            end
            MODE_BLEND:
            begin
                if (alpha == ALPHA_CLEAR)
                begin
                    result = pair.dest;
                end
                else if (opaque)
                begin
                    result = pair.src;
                end
                else
                begin
                    result = mixed;
                end
            end
            MODE_HALF:
            begin
                result = opaque ? halved : pair.dest;
            end
            MODE_KEY:
            begin
                result = opaque ? pair.src : pair.dest;
            end
            default:
            begin
                result = pair.dest;
            end
        endcase
    end

endmodule

[hdl/apb_out_stage.sv]
// result register on the master side
module apb_out_stage
    import apb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    input  logic [PIX_W-1:0] result,
    output logic             advance,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata    // out_pixel [31:0]
);

    logic             valid_reg;
    logic             valid_next;
    logic [PIX_W-1:0] data_reg;

    assign advance = !valid_reg || m_axis_tready;

    always_comb
    begin
        if (advance)
        begin
            valid_next = pair_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pair_valid)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

[hdl/argb_pixel_blend_core.sv]
// argb pixel blend core top level
// Composites a source ARGB8888 pixel onto a destination pixel using the
// operation held in the blend mode register (solid, alpha blend, fifty
// percent, opaque key). One request per clock is taken while the core is
// not stalled; each request is held in the input register and then the
// result register, around the per-channel 8x8 multiply-add logic.
// Back-pressure on the master side stalls both registers. The mode register
// may be written only while no request is in flight; cfg_ready is low while
// the core holds a pixel.
`include "argb_pixel_blend_core_macros.svh"

module argb_pixel_blend_core
    import apb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // dest_pixel [31:0], src_pixel [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // out_pixel [31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data         // blend_mode
);

    blend_mode_t      mode_reg;
    blend_mode_t      mode_next;
    logic             advance;
    logic             pair_valid;
    pix_pair_t        pair;
    logic [PIX_W-1:0] result;

    assign cfg_ready = !pair_valid && !m_axis_tvalid;

    always_comb
    begin
        if (cfg_valid && cfg_ready)
        begin
            mode_next = blend_mode_t'(cfg_data);
        end
        else
        begin
            mode_next = mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SOLID;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    apb_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .pair_valid    (pair_valid),
        .pair          (pair)
    );

    apb_blend_alu u_blend_alu (
        .mode   (mode_reg),
        .pair   (pair),
        .result (result)
    );

    apb_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair_valid    (pair_valid),
        .result        (result),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // a held pair that moves on always shows up as a result
    `APB_ASSERT(a_pair_to_result, clk, rst_n, pair_valid && advance |=> m_axis_tvalid)
    // input side only stalls when both registers are full and the sink waits
    `APB_ASSERT(a_stall_cause, clk, rst_n,
        !s_axis_tready |-> pair_valid && m_axis_tvalid && !m_axis_tready)
    // solid mode results are always opaque
    `APB_ASSERT(a_solid_opaque, clk, rst_n,
        m_axis_tvalid && mode_reg == MODE_SOLID |-> m_axis_tdata[31:24] == ALPHA_OPAQUE)
    // mode never changes while a request is in flight
    `APB_ASSERT_ALWAYS(a_mode_idle, clk, cfg_ready |-> !m_axis_tvalid && !pair_valid)

endmodule
